// ===== rtl/core/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, constants and pipeline word types for the SVPWM compare
// value calculator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int PERIOD_WIDTH = 16;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(1000);

    // Q1.15 inputs: fractional bits and product widths
    localparam int FRAC_W = SAMPLE_WIDTH - 1;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int ROT_W  = PROD_W + 1 - FRAC_W;

    localparam logic signed [PROD_W:0] ROUND_HALF = 1 <<< (FRAC_W - 1);

    // sqrt(3) in Q.16
    localparam int K_W    = 17;
    localparam int K_FRAC = 16;
    localparam logic signed [K_W:0] SQRT3_Q16 = 113512;

    // Scaled voltage widths
    localparam int PS_W = PERIOD_WIDTH + 1;
    localparam int AK_W = ROT_W + K_W + 1;
    localparam int UA_W = AK_W + PS_W;
    localparam int BP_W = ROT_W + PS_W;
    localparam int WIDE_W = UA_W + 3;

    // X, Y, Z carry CNT_FRAC fractional bits of a count
    localparam int CNT_FRAC  = FRAC_W + K_FRAC + 1;
    localparam int DIV_SHIFT = CNT_FRAC + 1;
    localparam int COUNT_W   = WIDE_W - CNT_FRAC;

    // Sector 1..6 as reported on the output
    typedef enum logic [2:0] {
        SECTOR_1 = 3'd0,
        SECTOR_2 = 3'd1,
        SECTOR_3 = 3'd2,
        SECTOR_4 = 3'd3,
        SECTOR_5 = 3'd4,
        SECTOR_6 = 3'd5
    } sector_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] volt_d;
        logic signed [SAMPLE_WIDTH-1:0] volt_q;
        logic signed [SAMPLE_WIDTH-1:0] cos_angle;
        logic signed [SAMPLE_WIDTH-1:0] sin_angle;
    } sample_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] alpha;
        logic signed [ROT_W-1:0] beta;
    } park_t;

    // X, Y, Z and the sums the sector stage needs, scale 2^CNT_FRAC
    typedef struct packed {
        logic signed [WIDE_W-1:0] ua2;
        logic signed [WIDE_W-1:0] x;
        logic signed [WIDE_W-1:0] y;
        logic signed [WIDE_W-1:0] z;
        logic signed [WIDE_W-1:0] nx;
        logic signed [WIDE_W-1:0] ny;
        logic signed [WIDE_W-1:0] nz;
    } xyz_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] ta;
        logic signed [COUNT_W-1:0] tb;
        logic signed [COUNT_W-1:0] tc;
        sector_t                   sector;
    } cmp_t;

endpackage

// ===== rtl/core/svpwm_compare_calc.sv =====
// ----------------------------------------------------------------------------
// svpwm_compare_calc
// Space vector PWM compare values from a d/q voltage command.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output side is ready and returns one
// result word per input word, in order. The path has eight register stages:
// two for the inverse Park transform, three for the sqrt(3) and period
// scaling multipliers and the X/Y/Z sums, two for sector selection and the
// phase chain, and the output register with saturation. Each stage holds its
// word until the next stage frees up, so bubbles close and nothing is lost
// under back pressure. Write pwm_period only while no word is in flight.
// ----------------------------------------------------------------------------
module svpwm_compare_calc (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]      cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // volt_d, volt_q, cos_angle, sin_angle (from bit 0 up)
    input  logic [4*svpwm_pkg::SAMPLE_WIDTH-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // compare_a, compare_b, compare_c (from bit 0 up)
    output logic [3*svpwm_pkg::PERIOD_WIDTH-1:0]    m_tdata,
    // sector_index[2:0], clamped[3]
    output logic [3:0]                              m_tuser
);

    localparam int SW = svpwm_pkg::SAMPLE_WIDTH;
    localparam int PW = svpwm_pkg::PERIOD_WIDTH;
    localparam int CW = svpwm_pkg::COUNT_W;

    logic [PW-1:0] pwm_period_reg;

    svpwm_pkg::sample_t sample;
    svpwm_pkg::park_t   park_data;
    svpwm_pkg::xyz_t    xyz_data;
    svpwm_pkg::cmp_t    cmp_data;
    logic park_valid, park_ready;
    logic xyz_valid, xyz_ready;
    logic cmp_valid, cmp_ready;

    logic              out_valid_reg;
    logic [PW-1:0]     cmp_a_reg, cmp_b_reg, cmp_c_reg;
    logic [PW-1:0]     cmp_a_next, cmp_b_next, cmp_c_next;
    logic [2:0]        sector_reg, sector_next;
    logic              clamped_reg, clamped_next;
    logic              clip_a, clip_b, clip_c;

    // Saturate a count to 0..period and report whether it was clipped
    function automatic logic [PW:0] sat_count(input logic signed [CW-1:0] t,
                                              input logic [PW-1:0] p);
        logic [PW:0] res;
        if (t[CW-1]) begin
            res = {1'b1, {PW{1'b0}}};
        end else if (t > $signed(CW'(p))) begin
            res = {1'b1, p};
        end else begin
            res = {1'b0, PW'(t)};
        end
        return res;
    endfunction

    // Period register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg <= svpwm_pkg::PERIOD_RESET;
        end else if (cfg_we) begin
            pwm_period_reg <= cfg_wdata;
        end
    end

    // Unpack the input word
    assign sample.volt_d    = s_tdata[SW-1:0];
    assign sample.volt_q    = s_tdata[2*SW-1:SW];
    assign sample.cos_angle = s_tdata[3*SW-1:2*SW];
    assign sample.sin_angle = s_tdata[4*SW-1:3*SW];

    svpwm_park u_park (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (sample),
        .out_valid (park_valid),
        .out_ready (park_ready),
        .out_data  (park_data)
    );

    svpwm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .period    (pwm_period_reg),
        .in_valid  (park_valid),
        .in_ready  (park_ready),
        .in_data   (park_data),
        .out_valid (xyz_valid),
        .out_ready (xyz_ready),
        .out_data  (xyz_data)
    );

    svpwm_sector u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .period    (pwm_period_reg),
        .in_valid  (xyz_valid),
        .in_ready  (xyz_ready),
        .in_data   (xyz_data),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready),
        .out_data  (cmp_data)
    );

    // Stage 8: saturate and flag
    always_comb begin
        {clip_a, cmp_a_next} = sat_count(cmp_data.ta, pwm_period_reg);
        {clip_b, cmp_b_next} = sat_count(cmp_data.tb, pwm_period_reg);
        {clip_c, cmp_c_next} = sat_count(cmp_data.tc, pwm_period_reg);
        clamped_next = clip_a || clip_b || clip_c;
        sector_next  = cmp_data.sector;
    end

    assign cmp_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmp_ready) begin
            out_valid_reg <= cmp_valid;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (cmp_ready && cmp_valid) begin
            cmp_a_reg   <= cmp_a_next;
            cmp_b_reg   <= cmp_b_next;
            cmp_c_reg   <= cmp_c_next;
            sector_reg  <= sector_next;
            clamped_reg <= clamped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {cmp_c_reg, cmp_b_reg, cmp_a_reg};
    assign m_tuser  = {clamped_reg, sector_reg};

endmodule

// ===== rtl/core/svpwm_park.sv =====
// ----------------------------------------------------------------------------
// svpwm_park
// Inverse Park transform: two register stages, products then rounded sums.
// ----------------------------------------------------------------------------
module svpwm_park (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  svpwm_pkg::sample_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output svpwm_pkg::park_t  out_data
);

    logic v1_reg, v2_reg;
    logic rdy1, rdy2;

    logic signed [svpwm_pkg::PROD_W-1:0] qc_reg, ds_reg, dc_reg, qs_reg;
    logic signed [svpwm_pkg::PROD_W-1:0] qc_next, ds_next, dc_next, qs_next;
    logic signed [svpwm_pkg::PROD_W:0]   alpha_sum, beta_sum;
    svpwm_pkg::park_t park_reg, park_next;

    // Stage advances when empty or when its word moves on
    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage 1: four products
    assign qc_next = in_data.volt_q * in_data.cos_angle;
    assign ds_next = in_data.volt_d * in_data.sin_angle;
    assign dc_next = in_data.volt_d * in_data.cos_angle;
    assign qs_next = in_data.volt_q * in_data.sin_angle;

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            qc_reg <= qc_next;
            ds_reg <= ds_next;
            dc_reg <= dc_next;
            qs_reg <= qs_next;
        end
    end

    // Stage 2: alpha and beta, rounded half up to Q.15
    always_comb begin
        alpha_sum = (svpwm_pkg::PROD_W+1)'(qc_reg) + (svpwm_pkg::PROD_W+1)'(ds_reg)
                  + svpwm_pkg::ROUND_HALF;
        beta_sum  = (svpwm_pkg::PROD_W+1)'(dc_reg) - (svpwm_pkg::PROD_W+1)'(qs_reg)
                  + svpwm_pkg::ROUND_HALF;
        park_next.alpha = svpwm_pkg::ROT_W'(alpha_sum >>> svpwm_pkg::FRAC_W);
        park_next.beta  = svpwm_pkg::ROT_W'(beta_sum >>> svpwm_pkg::FRAC_W);
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            park_reg <= park_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = park_reg;

endmodule

// ===== rtl/core/svpwm_scale.sv =====
// ----------------------------------------------------------------------------
// svpwm_scale
// Scale alpha by sqrt(3) and the period, beta by minus the period, and form
// X, Y, Z. Three register stages.
// ----------------------------------------------------------------------------
module svpwm_scale (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]  period,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  svpwm_pkg::park_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output svpwm_pkg::xyz_t                     out_data
);

    logic v3_reg, v4_reg, v5_reg;
    logic rdy3, rdy4, rdy5;

    logic signed [svpwm_pkg::PS_W-1:0]   p_s;
    logic signed [svpwm_pkg::AK_W-1:0]   ak_reg, ak_next;
    logic signed [svpwm_pkg::BP_W-1:0]   bp_reg, bp_next;
    logic signed [svpwm_pkg::WIDE_W-1:0] ua_reg, ua_next;
    logic signed [svpwm_pkg::WIDE_W-1:0] ub_reg, ub_next;
    logic signed [svpwm_pkg::UA_W-1:0]   ua_prod;
    svpwm_pkg::xyz_t xyz_reg, xyz_next;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= in_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    assign p_s = $signed({1'b0, period});

    // Stage 3: alpha * sqrt(3), beta * period
    assign ak_next = in_data.alpha * svpwm_pkg::SQRT3_Q16;
    assign bp_next = in_data.beta * p_s;

    always_ff @(posedge aclk) begin
        if (rdy3 && in_valid) begin
            ak_reg <= ak_next;
            bp_reg <= bp_next;
        end
    end

    // Stage 4: u_alpha and u_beta, both at scale 2^(CNT_FRAC-1)
    assign ua_prod = ak_reg * p_s;
    assign ua_next = svpwm_pkg::WIDE_W'(ua_prod);
    assign ub_next = -(svpwm_pkg::WIDE_W'(bp_reg) <<< svpwm_pkg::K_FRAC);

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            ua_reg <= ua_next;
            ub_reg <= ub_next;
        end
    end

    // Stage 5: X, Y, Z, their negatives and 2*u_alpha
    always_comb begin
        xyz_next.ua2 = ua_reg <<< 1;
        xyz_next.x   = ub_reg <<< 1;
        xyz_next.y   = ua_reg + ub_reg;
        xyz_next.z   = ub_reg - ua_reg;
        xyz_next.nx  = -(ub_reg <<< 1);
        xyz_next.ny  = -ua_reg - ub_reg;
        xyz_next.nz  = ua_reg - ub_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            xyz_reg <= xyz_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = xyz_reg;

endmodule

// ===== rtl/core/svpwm_sector.sv =====
// ----------------------------------------------------------------------------
// svpwm_sector
// Pick the sector from the signs of X, Y, Z, then form the unclamped phase
// compare values. Two register stages.
// ----------------------------------------------------------------------------
module svpwm_sector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [svpwm_pkg::PERIOD_WIDTH-1:0]  period,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  svpwm_pkg::xyz_t                     in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output svpwm_pkg::cmp_t                     out_data
);

    localparam int WW = svpwm_pkg::WIDE_W;
    localparam int CW = svpwm_pkg::COUNT_W;

    logic v6_reg, v7_reg;
    logic rdy6, rdy7;

    logic y_neg, z_neg, x_pos;
    logic signed [WW-1:0] diff, half_w, sum_w;

    svpwm_pkg::sector_t sector_reg, sector_next;
    logic signed [CW-1:0] ta_reg, ta_next;
    logic signed [CW-1:0] fz_reg, fz_next;
    logic signed [CW-1:0] fny_reg, fny_next;
    logic signed [CW-1:0] fnx_reg, fnx_next;
    logic signed [CW-1:0] fx_reg, fx_next;
    svpwm_pkg::cmp_t cmp_reg, cmp_next;

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign in_ready = rdy6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (rdy6) begin
                v6_reg <= in_valid;
            end
            if (rdy7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    // Stage 6: sector, phase A and the floored X, Y, Z terms
    always_comb begin
        y_neg = in_data.y[WW-1];
        z_neg = in_data.z[WW-1];
        x_pos = !in_data.x[WW-1] && (in_data.x != '0);

        if (y_neg) begin
            if (z_neg) begin
                sector_next = svpwm_pkg::SECTOR_5;
            end else if (x_pos) begin
                sector_next = svpwm_pkg::SECTOR_3;
            end else begin
                sector_next = svpwm_pkg::SECTOR_4;
            end
        end else begin
            if (!z_neg) begin
                sector_next = svpwm_pkg::SECTOR_2;
            end else if (x_pos) begin
                sector_next = svpwm_pkg::SECTOR_1;
            end else begin
                sector_next = svpwm_pkg::SECTOR_6;
            end
        end

        // Y-Z, X-Z and Y-X reduce to 2*u_alpha, Y and -Z
        case (sector_next)
            svpwm_pkg::SECTOR_2, svpwm_pkg::SECTOR_5: begin
                diff = in_data.ua2;
            end
            svpwm_pkg::SECTOR_1, svpwm_pkg::SECTOR_4: begin
                diff = in_data.y;
            end
            default: begin
                diff = in_data.nz;
            end
        endcase

        half_w  = $signed(WW'(period >> 1) << svpwm_pkg::CNT_FRAC);
        sum_w   = half_w + diff;
        ta_next = CW'(sum_w >>> svpwm_pkg::DIV_SHIFT) + $signed(CW'(period >> 2));

        fz_next  = CW'(in_data.z >>> svpwm_pkg::CNT_FRAC);
        fny_next = CW'(in_data.ny >>> svpwm_pkg::CNT_FRAC);
        fnx_next = CW'(in_data.nx >>> svpwm_pkg::CNT_FRAC);
        fx_next  = CW'(in_data.x >>> svpwm_pkg::CNT_FRAC);
    end

    always_ff @(posedge aclk) begin
        if (rdy6 && in_valid) begin
            sector_reg <= sector_next;
            ta_reg     <= ta_next;
            fz_reg     <= fz_next;
            fny_reg    <= fny_next;
            fnx_reg    <= fnx_next;
            fx_reg     <= fx_next;
        end
    end

    // Stage 7: phases B and C; sectors 3 and 6 derive B from C
    always_comb begin
        cmp_next.ta     = ta_reg;
        cmp_next.sector = sector_reg;
        case (sector_reg)
            svpwm_pkg::SECTOR_2, svpwm_pkg::SECTOR_5: begin
                cmp_next.tb = ta_reg + fz_reg;
                cmp_next.tc = ta_reg + fny_reg;
            end
            svpwm_pkg::SECTOR_1, svpwm_pkg::SECTOR_4: begin
                cmp_next.tb = ta_reg + fz_reg;
                cmp_next.tc = ta_reg + fz_reg + fnx_reg;
            end
            default: begin
                cmp_next.tc = ta_reg + fny_reg;
                cmp_next.tb = ta_reg + fny_reg + fx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy7 && v6_reg) begin
            cmp_reg <= cmp_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_data  = cmp_reg;

endmodule
